[design/cls_pkg.sv]
// ----------------------------------------------------------------------------
// cls_pkg
// Shared types, command and status codes for the cursor list store.
// ----------------------------------------------------------------------------
package cls_pkg;

    // Default sizing
    localparam int CAPACITY_DEF   = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    // Port field types
    typedef logic [3:0]  cmd_t;
    typedef logic [31:0] value_t;
    typedef logic [9:0]  pos_t;
    typedef logic [1:0]  status_t;
    typedef logic [31:0] rdata_t;
    typedef logic [10:0] count_out_t;
    typedef logic [9:0]  cursor_out_t;

    localparam int POS_W = $bits(pos_t);

    // Command codes
    localparam cmd_t CMD_INS_BEFORE = 4'd0;
    localparam cmd_t CMD_INS_AFTER  = 4'd1;
    localparam cmd_t CMD_DELETE     = 4'd2;
    localparam cmd_t CMD_NEXT       = 4'd3;
    localparam cmd_t CMD_PREV       = 4'd4;
    localparam cmd_t CMD_FIRST      = 4'd5;
    localparam cmd_t CMD_LAST       = 4'd6;
    localparam cmd_t CMD_RD_CUR     = 4'd7;
    localparam cmd_t CMD_RD_IDX     = 4'd8;
    localparam cmd_t CMD_WR_IDX     = 4'd9;
    localparam cmd_t CMD_WR_CUR     = 4'd10;

    // Status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_RANGE = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

    // Result handed from the sequencer to the output stage
    typedef struct packed {
        status_t     status;
        logic        moved;
        rdata_t      read_data;
        count_out_t  element_count;
        cursor_out_t cursor_position;
    } res_t;

endpackage

[design/cursor_list_store.sv]
// ----------------------------------------------------------------------------
// cursor_list_store
// Ordered list in a fixed RAM with a cursor; one result transaction per command.
// ----------------------------------------------------------------------------
// Commands are handled one at a time. in_stall is high from acceptance until
// the result moves into the output register, which then holds it for the
// downstream side while the next command is taken. Cursor moves, reads,
// writes, refused commands, unused codes and a delete of the last entry go
// straight to the result state. An insert or delete that copies k entries
// through the single RAM (one read and one write per cycle, pipelined) first
// passes through the shift and finish states, where k is the number of
// entries behind the insert or delete point: up to CAPACITY - 1 for an
// insert before index 0. An insert that copies nothing still passes through
// both. A stalled output register keeps in_stall high until the result can
// move in. Entry storage has no reset; count and cursor reset to an empty
// list with no cursor, so the block is ready right after reset.
module cursor_list_store #(
    parameter int CAPACITY   = cls_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = cls_pkg::DATA_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  cls_pkg::cmd_t          command,
    input  cls_pkg::value_t        value,
    input  cls_pkg::pos_t          position,
    output logic                   out_valid,
    input  logic                   out_stall,
    output cls_pkg::status_t       status,
    output logic                   moved,
    output cls_pkg::rdata_t        read_data,
    output cls_pkg::count_out_t    element_count,
    output cls_pkg::cursor_out_t   cursor_position
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  res_valid;
    logic                  res_take;
    cls_pkg::res_t         res;

    logic                  out_valid_reg, out_valid_next;
    cls_pkg::res_t         out_reg;

    cls_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (in_valid),
        .cmd_stall (in_stall),
        .command   (command),
        .value     (value),
        .position  (position),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    cls_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // load the output register when it is empty or being drained
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign moved           = out_reg.moved;
    assign read_data       = out_reg.read_data;
    assign element_count   = out_reg.element_count;
    assign cursor_position = out_reg.cursor_position;

`ifndef ASSERT_OFF
    // while a command is open the sequencer must not look ready
    a_ready_means_no_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_stall |-> !res_valid
    ) else $error("input ready while a result is still pending");

    // a handed-over result shows up on the output next cycle
    a_take_fills_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_take |=> out_valid
    ) else $error("taken result did not reach the output register");

    a_moved_only_ok: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && moved |-> status == cls_pkg::ST_OK
    ) else $error("moved flag set on a failed command");

    a_read_data_zero_on_error: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && (status != cls_pkg::ST_OK) |-> read_data == '0
    ) else $error("read data not zero on a failed command");
`endif

endmodule

[design/cls_ram.sv]
// ----------------------------------------------------------------------------
// cls_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/cls_ctrl.sv]
// ----------------------------------------------------------------------------
// cls_ctrl
// Command sequencer: decodes a transaction, keeps count and cursor, drives the
// entry RAM, and runs the read-then-write copy loop that opens or closes a gap.
// ----------------------------------------------------------------------------
module cls_ctrl #(
    parameter int CAPACITY   = cls_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = cls_pkg::DATA_WIDTH_DEF,
    parameter int IDX_W      = $clog2(CAPACITY),
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // command side
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  cls_pkg::cmd_t         command,
    input  cls_pkg::value_t       value,
    input  cls_pkg::pos_t         position,
    // result side
    output logic                  res_valid,
    input  logic                  res_take,
    output cls_pkg::res_t         res,
    // entry RAM
    output logic                  ram_we,
    output logic [IDX_W-1:0]      ram_waddr,
    output logic [DATA_WIDTH-1:0] ram_wdata,
    output logic                  ram_re,
    output logic [IDX_W-1:0]      ram_raddr,
    input  logic [DATA_WIDTH-1:0] ram_rdata
);

    localparam int CMP_W = (CNT_W > cls_pkg::POS_W) ? CNT_W : cls_pkg::POS_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_FIN   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // control state
    logic [1:0]            state_reg,   state_next;
    logic [CNT_W-1:0]      count_reg,   count_next;
    logic [IDX_W-1:0]      cursor_reg,  cursor_next;
    logic [CNT_W-1:0]      issue_reg,   issue_next;
    logic                  pend_reg,    pend_next;

    // payload state
    logic [IDX_W-1:0]      src_reg,     src_next;
    logic [IDX_W-1:0]      wdst_reg,    wdst_next;
    logic                  up_reg,      up_next;
    logic                  fin_en_reg,  fin_en_next;
    logic [IDX_W-1:0]      fin_addr_reg, fin_addr_next;
    logic [DATA_WIDTH-1:0] fin_data_reg, fin_data_next;
    cls_pkg::status_t      status_reg,  status_next;
    logic                  moved_reg,   moved_next;
    logic                  rd_reg,      rd_next;

    logic                  accept;
    logic                  empty;
    logic                  full;
    logic                  pos_ok;
    logic [CNT_W-1:0]      cur_ext;
    logic [CNT_W-1:0]      cur_p1;
    logic [CNT_W-1:0]      cnt_m1;
    logic [IDX_W-1:0]      pos_idx;
    logic [DATA_WIDTH-1:0] val_d;

    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign pos_ok  = (CMP_W'(position) < CMP_W'(count_reg));
    assign cur_ext = CNT_W'(cursor_reg);
    assign cur_p1  = cur_ext + CNT_W'(1);
    assign cnt_m1  = count_reg - CNT_W'(1);
    assign pos_idx = IDX_W'(position);
    assign val_d   = DATA_WIDTH'(value);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        src_next      = src_reg;
        wdst_next     = wdst_reg;
        up_next       = up_reg;
        fin_en_next   = fin_en_reg;
        fin_addr_next = fin_addr_reg;
        fin_data_next = fin_data_reg;
        status_next   = status_reg;
        moved_next    = moved_reg;
        rd_next       = rd_reg;

        ram_re    = 1'b0;
        ram_raddr = src_reg;
        ram_we    = 1'b0;
        ram_waddr = wdst_reg;
        ram_wdata = ram_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next    = S_DONE;
                    status_next   = cls_pkg::ST_OK;
                    moved_next    = 1'b0;
                    rd_next       = 1'b0;
                    fin_en_next   = 1'b0;
                    fin_data_next = val_d;
                    pend_next     = 1'b0;
                    case (command)
                        cls_pkg::CMD_INS_BEFORE,
                        cls_pkg::CMD_INS_AFTER:
                        begin
                            if (full)
                            begin
                                status_next = cls_pkg::ST_FULL;
                            end
                            else
                            begin
                                // open a gap from the top end down, then drop the new entry in
                                state_next  = S_SHIFT;
                                up_next     = 1'b0;
                                src_next    = IDX_W'(cnt_m1);
                                wdst_next   = IDX_W'(count_reg);
                                fin_en_next = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                                if (empty)
                                begin
                                    issue_next    = '0;
                                    fin_addr_next = '0;
                                    cursor_next   = '0;
                                end
                                else if (command == cls_pkg::CMD_INS_BEFORE)
                                begin
                                    issue_next    = count_reg - cur_ext;
                                    fin_addr_next = cursor_reg;
                                    cursor_next   = IDX_W'(cur_p1);
                                end
                                else
                                begin
                                    issue_next    = cnt_m1 - cur_ext;
                                    fin_addr_next = IDX_W'(cur_p1);
                                end
                            end
                        end
                        cls_pkg::CMD_DELETE:
                        begin
                            if (empty)
                            begin
                                status_next = cls_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                                if (cur_ext == cnt_m1)
                                begin
                                    // last entry goes: fall back one place
                                    if (cursor_reg != '0)
                                    begin
                                        cursor_next = cursor_reg - IDX_W'(1);
                                    end
                                end
                                else
                                begin
                                    // close the gap from the cursor upward
                                    state_next = S_SHIFT;
                                    up_next    = 1'b1;
                                    src_next   = IDX_W'(cur_p1);
                                    wdst_next  = cursor_reg;
                                    issue_next = cnt_m1 - cur_ext;
                                end
                            end
                        end
                        cls_pkg::CMD_NEXT:
                        begin
                            if (empty)
                            begin
                                status_next = cls_pkg::ST_EMPTY;
                            end
                            else if (cur_p1 < count_reg)
                            begin
                                cursor_next = IDX_W'(cur_p1);
                                moved_next  = 1'b1;
                            end
                        end
                        cls_pkg::CMD_PREV:
                        begin
                            if (empty)
                            begin
                                status_next = cls_pkg::ST_EMPTY;
                            end
                            else if (cursor_reg != '0)
                            begin
                                cursor_next = cursor_reg - IDX_W'(1);
                                moved_next  = 1'b1;
                            end
                        end
                        cls_pkg::CMD_FIRST:
                        begin
                            if (empty)
                            begin
                                status_next = cls_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cursor_next = '0;
                            end
                        end
                        cls_pkg::CMD_LAST:
                        begin
                            if (empty)
                            begin
                                status_next = cls_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cursor_next = IDX_W'(cnt_m1);
                            end
                        end
                        cls_pkg::CMD_RD_CUR:
                        begin
                            if (empty)
                            begin
                                status_next = cls_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = cursor_reg;
                                rd_next   = 1'b1;
                            end
                        end
                        cls_pkg::CMD_RD_IDX:
                        begin
                            if (!pos_ok)
                            begin
                                status_next = cls_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = pos_idx;
                                rd_next   = 1'b1;
                            end
                        end
                        cls_pkg::CMD_WR_IDX:
                        begin
                            if (!pos_ok)
                            begin
                                status_next = cls_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = pos_idx;
                                ram_wdata = val_d;
                            end
                        end
                        cls_pkg::CMD_WR_CUR:
                        begin
                            if (empty)
                            begin
                                status_next = cls_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cursor_reg;
                                ram_wdata = val_d;
                            end
                        end
                        default:
                        begin
                            status_next = cls_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                // read one entry ahead, write the one fetched last cycle
                ram_re = (issue_reg != '0);
                ram_we = pend_reg;
                if (issue_reg != '0)
                begin
                    issue_next = issue_reg - CNT_W'(1);
                    src_next   = up_reg ? src_reg + IDX_W'(1) : src_reg - IDX_W'(1);
                    pend_next  = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    wdst_next = up_reg ? wdst_reg + IDX_W'(1) : wdst_reg - IDX_W'(1);
                end
                if ((issue_reg == '0) && !pend_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                ram_we     = fin_en_reg;
                ram_waddr  = fin_addr_reg;
                ram_wdata  = fin_data_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
            issue_reg  <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            issue_reg  <= issue_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        wdst_reg     <= wdst_next;
        up_reg       <= up_next;
        fin_en_reg   <= fin_en_next;
        fin_addr_reg <= fin_addr_next;
        fin_data_reg <= fin_data_next;
        status_reg   <= status_next;
        moved_reg    <= moved_next;
        rd_reg       <= rd_next;
    end

    // read data sits in the RAM output register until the next command reads
    assign res_valid           = (state_reg == S_DONE);
    assign res.status          = status_reg;
    assign res.moved           = moved_reg;
    assign res.read_data       = rd_reg ? cls_pkg::rdata_t'(ram_rdata) : '0;
    assign res.element_count   = cls_pkg::count_out_t'(count_reg);
    assign res.cursor_position = cls_pkg::cursor_out_t'(cursor_reg);

endmodule

[bench/cursor_list_store_tb.sv]
// ----------------------------------------------------------------------------
// cursor_list_store_tb
// Self-checking bench for the cursor list store. A directed table covers the
// empty list, both list ends, error codes and unused commands. A growth phase
// builds a list of a few dozen entries and runs long shifts at its head.
// Random command traffic on small lists follows. Every result transaction is
// compared with the table's expected result or an in-bench model of the list.
// Random idle bursts are applied on both the command and result sides.
// ----------------------------------------------------------------------------
module cursor_list_store_tb;

    localparam int            CAPACITY      = cls_pkg::CAPACITY_DEF;
    localparam int            GROW_LEN      = 48;
    localparam int            RANDOM_OPS    = 500;
    localparam int            QUIET_TAIL    = 80;
    localparam cls_pkg::cmd_t CMD_UNUSED_LO = 4'd11;
    localparam cls_pkg::cmd_t CMD_UNUSED_HI = 4'd15;

    typedef struct {
        cls_pkg::cmd_t   op;
        cls_pkg::value_t val;
        cls_pkg::pos_t   pos;
        bit              typed;
        cls_pkg::res_t   res;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    cls_pkg::cmd_t        command   = '0;
    cls_pkg::value_t      value     = '0;
    cls_pkg::pos_t        position  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    cls_pkg::status_t     status;
    logic                 moved;
    cls_pkg::rdata_t      read_data;
    cls_pkg::count_out_t  element_count;
    cls_pkg::cursor_out_t cursor_position;

    // List contents as the block should hold them
    cls_pkg::value_t entries [CAPACITY];
    int unsigned     n_entries = 0;
    int unsigned     cur_idx   = 0;
    int unsigned     peak_len  = 0;

    cls_pkg::res_t   replies_due[$];
    bit              cur_typed = 1'b0;
    cls_pkg::res_t   cur_res   = '0;
    int              errors    = 0;
    int              n_cmds    = 0;
    int              n_checked = 0;
    int              n_empty   = 0;
    int              n_range   = 0;
    int              n_full    = 0;

    bit              idle_on   = 1'b1;
    int              gap_pct   = 25;
    int              stall_pct = 25;
    int              stall_left = 0;

    dir_row_t dir_rows [0:25] = '{
        '{cls_pkg::CMD_RD_CUR, 32'h0, 10'd0, 1'b1,
          '{cls_pkg::ST_EMPTY, 1'b0, 32'h0, 11'd0, 10'd0}},
        '{cls_pkg::CMD_DELETE, 32'h0, 10'd0, 1'b1,
          '{cls_pkg::ST_EMPTY, 1'b0, 32'h0, 11'd0, 10'd0}},
        '{cls_pkg::CMD_NEXT, 32'h0, 10'd0, 1'b1,
          '{cls_pkg::ST_EMPTY, 1'b0, 32'h0, 11'd0, 10'd0}},
        '{cls_pkg::CMD_PREV, 32'h0, 10'd0, 1'b1,
          '{cls_pkg::ST_EMPTY, 1'b0, 32'h0, 11'd0, 10'd0}},
        '{cls_pkg::CMD_FIRST, 32'h0, 10'd0, 1'b1,
          '{cls_pkg::ST_EMPTY, 1'b0, 32'h0, 11'd0, 10'd0}},
        '{cls_pkg::CMD_LAST, 32'h0, 10'd0, 1'b1,
          '{cls_pkg::ST_EMPTY, 1'b0, 32'h0, 11'd0, 10'd0}},
        '{cls_pkg::CMD_WR_CUR, 32'h12345678, 10'd0, 1'b1,
          '{cls_pkg::ST_EMPTY, 1'b0, 32'h0, 11'd0, 10'd0}},
        '{cls_pkg::CMD_RD_IDX, 32'h0, 10'd0, 1'b1,
          '{cls_pkg::ST_RANGE, 1'b0, 32'h0, 11'd0, 10'd0}},
        '{cls_pkg::CMD_WR_IDX, 32'hFFFFFFFF, 10'd1023, 1'b1,
          '{cls_pkg::ST_RANGE, 1'b0, 32'h0, 11'd0, 10'd0}},
        '{CMD_UNUSED_LO, 32'h0, 10'd0, 1'b1,
          '{cls_pkg::ST_OK, 1'b0, 32'h0, 11'd0, 10'd0}},
        '{CMD_UNUSED_HI, 32'hFFFFFFFF, 10'd1023, 1'b1,
          '{cls_pkg::ST_OK, 1'b0, 32'h0, 11'd0, 10'd0}},
        '{cls_pkg::CMD_INS_BEFORE, 32'hFFFFFFFF, 10'd0, 1'b1,
          '{cls_pkg::ST_OK, 1'b0, 32'h0, 11'd1, 10'd0}},
        '{cls_pkg::CMD_INS_AFTER, 32'h0, 10'd0, 1'b1,
          '{cls_pkg::ST_OK, 1'b0, 32'h0, 11'd2, 10'd0}},
        '{cls_pkg::CMD_RD_CUR, 32'h0, 10'd0, 1'b1,
          '{cls_pkg::ST_OK, 1'b0, 32'hFFFFFFFF, 11'd2, 10'd0}},
        '{cls_pkg::CMD_PREV, 32'h0, 10'd0, 1'b1,
          '{cls_pkg::ST_OK, 1'b0, 32'h0, 11'd2, 10'd0}},
        '{cls_pkg::CMD_NEXT,       32'h0,        10'd0, 1'b0, '0},
        '{cls_pkg::CMD_NEXT,       32'h0,        10'd0, 1'b0, '0},
        '{cls_pkg::CMD_RD_IDX,     32'h0,        10'd1, 1'b0, '0},
        '{cls_pkg::CMD_INS_BEFORE, 32'hA5A5A5A5, 10'd0, 1'b0, '0},
        '{cls_pkg::CMD_WR_IDX,     32'h5A5A5A5A, 10'd0, 1'b0, '0},
        '{cls_pkg::CMD_WR_CUR,     32'hC3C3C3C3, 10'd0, 1'b0, '0},
        '{cls_pkg::CMD_LAST,       32'h0,        10'd0, 1'b0, '0},
        '{cls_pkg::CMD_DELETE,     32'h0,        10'd0, 1'b0, '0},
        '{cls_pkg::CMD_FIRST,      32'h0,        10'd0, 1'b0, '0},
        '{cls_pkg::CMD_DELETE,     32'h0,        10'd0, 1'b0, '0},
        '{cls_pkg::CMD_DELETE, 32'h0, 10'd0, 1'b1,
          '{cls_pkg::ST_OK, 1'b0, 32'h0, 11'd0, 10'd0}}
    };

    cursor_list_store DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .value           (value),
        .position        (position),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .moved           (moved),
        .read_data       (read_data),
        .element_count   (element_count),
        .cursor_position (cursor_position)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Apply one command to the list and return the result it should give
    function automatic cls_pkg::res_t list_apply(cls_pkg::cmd_t op, cls_pkg::value_t val,
                                                 cls_pkg::pos_t pos);
        cls_pkg::res_t r;
        int unsigned   i;
        r = '0;
        case (op)
            cls_pkg::CMD_INS_BEFORE, cls_pkg::CMD_INS_AFTER:
            begin
                if (n_entries >= CAPACITY)
                    r.status = cls_pkg::ST_FULL;
                else if (n_entries == 0)
                begin
                    entries[0] = val;
                    cur_idx = 0;
                    n_entries = 1;
                end
                else if (op == cls_pkg::CMD_INS_BEFORE)
                begin
                    for (i = n_entries; i > cur_idx; i--)
                        entries[i] = entries[i - 1];
                    entries[cur_idx] = val;
                    cur_idx++;
                    n_entries++;
                end
                else
                begin
                    for (i = n_entries; i > cur_idx + 1; i--)
                        entries[i] = entries[i - 1];
                    entries[cur_idx + 1] = val;
                    n_entries++;
                end
            end
            cls_pkg::CMD_DELETE:
            begin
                if (n_entries == 0)
                    r.status = cls_pkg::ST_EMPTY;
                else if (cur_idx == n_entries - 1)
                begin
                    cur_idx = (cur_idx == 0) ? 0 : cur_idx - 1;
                    n_entries--;
                end
                else
                begin
                    for (i = cur_idx + 1; i < n_entries; i++)
                        entries[i - 1] = entries[i];
                    n_entries--;
                end
            end
            cls_pkg::CMD_NEXT:
            begin
                if (n_entries == 0)
                    r.status = cls_pkg::ST_EMPTY;
                else if (cur_idx + 1 < n_entries)
                begin
                    cur_idx++;
                    r.moved = 1'b1;
                end
            end
            cls_pkg::CMD_PREV:
            begin
                if (n_entries == 0)
                    r.status = cls_pkg::ST_EMPTY;
                else if (cur_idx > 0)
                begin
                    cur_idx--;
                    r.moved = 1'b1;
                end
            end
            cls_pkg::CMD_FIRST:
            begin
                if (n_entries == 0)
                    r.status = cls_pkg::ST_EMPTY;
                else
                    cur_idx = 0;
            end
            cls_pkg::CMD_LAST:
            begin
                if (n_entries == 0)
                    r.status = cls_pkg::ST_EMPTY;
                else
                    cur_idx = n_entries - 1;
            end
            cls_pkg::CMD_RD_CUR:
            begin
                if (n_entries == 0)
                    r.status = cls_pkg::ST_EMPTY;
                else
                    r.read_data = entries[cur_idx];
            end
            cls_pkg::CMD_RD_IDX:
            begin
                if (pos >= n_entries)
                    r.status = cls_pkg::ST_RANGE;
                else
                    r.read_data = entries[pos];
            end
            cls_pkg::CMD_WR_IDX:
            begin
                if (pos >= n_entries)
                    r.status = cls_pkg::ST_RANGE;
                else
                    entries[pos] = val;
            end
            cls_pkg::CMD_WR_CUR:
            begin
                if (n_entries == 0)
                    r.status = cls_pkg::ST_EMPTY;
                else
                    entries[cur_idx] = val;
            end
            default:
            begin
            end
        endcase
        if (n_entries == 0)
            cur_idx = 0;
        if (n_entries > peak_len)
            peak_len = n_entries;
        r.element_count   = cls_pkg::count_out_t'(n_entries);
        r.cursor_position = cls_pkg::cursor_out_t'(cur_idx);
        return r;
    endfunction

    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        cls_pkg::res_t want;
        cls_pkg::res_t nxt;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("result transaction with no command outstanding");
                    errors++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    n_checked++;
                    case (want.status)
                        cls_pkg::ST_EMPTY: n_empty++;
                        cls_pkg::ST_RANGE: n_range++;
                        cls_pkg::ST_FULL:  n_full++;
                        default:           ;
                    endcase
                    cmp_field("status", 32'(want.status), 32'(status));
                    cmp_field("moved", 32'(want.moved), 32'(moved));
                    cmp_field("read_data", want.read_data, read_data);
                    cmp_field("element_count", 32'(want.element_count),
                              32'(element_count));
                    cmp_field("cursor_position", 32'(want.cursor_position),
                              32'(cursor_position));
                end
            end
            if (in_valid && !in_stall)
            begin
                nxt = list_apply(command, value, position);
                replies_due.push_back(cur_typed ? cur_res : nxt);
                n_cmds++;
            end
        end
    end

    // Result-side stall bursts
    always @(negedge clk)
    begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 3);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_op(cls_pkg::cmd_t op, cls_pkg::value_t val, cls_pkg::pos_t pos,
                           bit typed = 1'b0, cls_pkg::res_t res = '0);
        int gap;
        if (idle_on && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        command   <= op;
        value     <= val;
        position  <= pos;
        cur_typed = typed;
        cur_res   = res;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_op();
        int            roll;
        int            ins_w;
        int            del_w;
        cls_pkg::cmd_t op;
        cls_pkg::pos_t pos;
        ins_w = (n_entries < 24) ? 30 : 15;
        del_w = (n_entries > 40) ? 30 : 12;
        roll  = $urandom_range(0, 99);
        if (roll < ins_w)
            op = $urandom_range(0, 1) ? cls_pkg::CMD_INS_BEFORE : cls_pkg::CMD_INS_AFTER;
        else if (roll < ins_w + del_w)
            op = cls_pkg::CMD_DELETE;
        else if (roll < 96)
            op = cls_pkg::cmd_t'($urandom_range(cls_pkg::CMD_NEXT, cls_pkg::CMD_WR_CUR));
        else
            op = cls_pkg::cmd_t'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        roll = $urandom_range(0, 99);
        if (n_entries > 0 && roll < 70)
            pos = cls_pkg::pos_t'($urandom_range(0, n_entries - 1));
        else if (roll < 90)
            pos = cls_pkg::pos_t'(n_entries + $urandom_range(0, 3));
        else
            pos = cls_pkg::pos_t'($urandom());
        send_op(op, $urandom(), pos);
    endtask

    initial
    begin
        int k;
        int w;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (k = 0; k < $size(dir_rows); k++)
            send_op(dir_rows[k].op, dir_rows[k].val, dir_rows[k].pos,
                    dir_rows[k].typed, dir_rows[k].res);
        hold_until_drained();

        // Grow the list; insert before the last entry keeps each shift short
        while (n_entries < GROW_LEN)
            send_op(cls_pkg::CMD_INS_BEFORE, $urandom(), cls_pkg::pos_t'($urandom()));
        // Long shifts: insert and delete near the head
        send_op(cls_pkg::CMD_FIRST, '0, '0);
        send_op(cls_pkg::CMD_INS_BEFORE, 32'hFFFFFFFF, '0);
        send_op(cls_pkg::CMD_RD_IDX, '0, '0);
        send_op(cls_pkg::CMD_DELETE, '0, '0);
        send_op(cls_pkg::CMD_INS_AFTER, 32'h0, '0);
        send_op(cls_pkg::CMD_LAST, '0, '0);
        send_op(cls_pkg::CMD_RD_CUR, '0, '0);
        send_op(cls_pkg::CMD_NEXT, '0, '0);
        hold_until_drained();

        for (k = 0; k < RANDOM_OPS; k++)
        begin
            if (k % 64 == 0)
            begin
                gap_pct   = 12 * $urandom_range(0, 3);
                stall_pct = 12 * $urandom_range(0, 3);
            end
            if (k == RANDOM_OPS - QUIET_TAIL)
                idle_on = 1'b0;
            random_op();
        end
        in_valid <= 1'b0;

        for (w = 0; w < 5000 && replies_due.size() != 0; w++)
            @(posedge clk);
        if (replies_due.size() != 0)
        begin
            $error("%0d result transactions never arrived", replies_due.size());
            errors++;
        end
        repeat (20) @(posedge clk);

        $display("Sent %0d commands, checked %0d results; list peaked at %0d entries.",
                 n_cmds, n_checked, peak_len);
        $display("Error statuses returned: %0d empty-list, %0d out-of-range, %0d full.",
                 n_empty, n_range, n_full);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout waiting for the list to respond");
        $display("Some tests failed");
        $finish;
    end

endmodule
